// File: sv/hett_pkg.sv
// shared types and constants for the heading error unit
package hett_pkg;

    // binary angle accumulator width, one full turn is 2^ACC_BITS
    localparam int ACC_BITS = 32;

    // fractional guard bits applied to the position differences
    localparam int GUARD_BITS = 24;

    // half a turn in the accumulator format
    localparam logic [ACC_BITS-1:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32
    localparam logic [ACC_BITS-1:0] ATAN_TURNS [0:31] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    // side flags that travel with each transaction through the chain
    typedef struct packed {
        logic zero;     // target coincides with current position
    } t_flags;

endpackage

// File: sv/heading_error_to_target_unit.sv
// top level: heading error to a target point through a pipelined cordic chain
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_operation, i_heading_now, i_pos_x,
//                                            i_pos_y, i_goal_x, i_goal_y
//  output    out        o_valid / i_stall    o_heading_error
//
// one transaction enters per clock while o_stall is low; the stages are the front stage,
// one cordic cell per micro-rotation and the rounding stage
// every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up and input is taken while a result waits
// o_stall rises only when every stage is full and the output is stalled
// synchronous active-low reset clears the valid bits; data registers are not reset
module heading_error_to_target_unit import hett_pkg::*; #(
    parameter int POSITION_BITS = 16,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_operation,
    input  logic [ANGLE_BITS-1:0]           i_heading_now,
    input  logic signed [POSITION_BITS-1:0] i_pos_x,
    input  logic signed [POSITION_BITS-1:0] i_pos_y,
    input  logic signed [POSITION_BITS-1:0] i_goal_x,
    input  logic signed [POSITION_BITS-1:0] i_goal_y,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ANGLE_BITS-1:0]           o_heading_error
);

    // difference magnitude, two bits for the cordic gain, sign, guard fraction
    localparam int XyBits = POSITION_BITS + 3 + GUARD_BITS;

    // stage k feeds cell k; stage CORDIC_STEPS feeds the rounding stage
    logic                      stg_valid [0:CORDIC_STEPS];
    logic                      stg_ready [0:CORDIC_STEPS];
    logic signed [XyBits-1:0]  stg_x     [0:CORDIC_STEPS];
    logic signed [XyBits-1:0]  stg_y     [0:CORDIC_STEPS];
    logic [ACC_BITS-1:0]       stg_z     [0:CORDIC_STEPS];
    t_flags                    stg_flags [0:CORDIC_STEPS];
    logic                      prep_ready;

    assign o_stall = !prep_ready;

    hett_prep #(
        .POSITION_BITS (POSITION_BITS),
        .ANGLE_BITS    (ANGLE_BITS),
        .XY_BITS       (XyBits)
    ) u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (prep_ready),
        .i_operation   (i_operation),
        .i_heading_now (i_heading_now),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_goal_x      (i_goal_x),
        .i_goal_y      (i_goal_y),
        .o_valid       (stg_valid[0]),
        .i_ready       (stg_ready[0]),
        .o_x           (stg_x[0]),
        .o_y           (stg_y[0]),
        .o_z           (stg_z[0]),
        .o_flags       (stg_flags[0])
    );

    // the micro-rotation chain, shift grows by one per cell
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        hett_cell #(
            .XY_BITS (XyBits),
            .SHIFT   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .o_ready (stg_ready[k]),
            .i_x     (stg_x[k]),
            .i_y     (stg_y[k]),
            .i_z     (stg_z[k]),
            .i_flags (stg_flags[k]),
            .o_valid (stg_valid[k+1]),
            .i_ready (stg_ready[k+1]),
            .o_x     (stg_x[k+1]),
            .o_y     (stg_y[k+1]),
            .o_z     (stg_z[k+1]),
            .o_flags (stg_flags[k+1])
        );
    end

    // only the angle leaves the chain; the vector and flags end here
    hett_post #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[CORDIC_STEPS]),
        .o_ready (stg_ready[CORDIC_STEPS]),
        .i_z     (stg_z[CORDIC_STEPS]),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_angle (o_heading_error)
    );

endmodule

// File: sv/hett_prep.sv
// front stage: position differences, half-plane fold and angle seed
module hett_prep import hett_pkg::*; #(
    parameter int POSITION_BITS = 16,
    parameter int ANGLE_BITS    = 16,
    parameter int XY_BITS       = 43
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_operation,
    input  logic [ANGLE_BITS-1:0]           i_heading_now,
    input  logic signed [POSITION_BITS-1:0] i_pos_x,
    input  logic signed [POSITION_BITS-1:0] i_pos_y,
    input  logic signed [POSITION_BITS-1:0] i_goal_x,
    input  logic signed [POSITION_BITS-1:0] i_goal_y,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [XY_BITS-1:0]       o_x,
    output logic signed [XY_BITS-1:0]       o_y,
    output logic [ACC_BITS-1:0]             o_z,
    output t_flags                          o_flags
);

    logic                            r_valid;
    logic signed [XY_BITS-1:0]       r_x;
    logic signed [XY_BITS-1:0]       r_y;
    logic [ACC_BITS-1:0]             r_z;
    t_flags                          r_flags;

    logic signed [POSITION_BITS:0]   dx;
    logic signed [POSITION_BITS:0]   dy;
    logic                            left;
    logic signed [XY_BITS-1:0]       n_x;
    logic signed [XY_BITS-1:0]       n_y;
    logic [ACC_BITS-1:0]             n_z;
    t_flags                          n_flags;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        dx = (POSITION_BITS+1)'(i_goal_x) - (POSITION_BITS+1)'(i_pos_x);
        dy = (POSITION_BITS+1)'(i_goal_y) - (POSITION_BITS+1)'(i_pos_y);
        left = dx[POSITION_BITS];
        // fold the left half plane onto the right one
        n_x = XY_BITS'(left ? -dx : dx) <<< GUARD_BITS;
        n_y = XY_BITS'(left ? -dy : dy) <<< GUARD_BITS;
        // heading and reverse offset go straight into the accumulator seed
        n_z = (left ? HALF_TURN : '0) + (i_operation ? HALF_TURN : '0)
            - (ACC_BITS'(i_heading_now) << (ACC_BITS - ANGLE_BITS));
        n_flags.zero = (dx == '0) && (dy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_flags = r_flags;

endmodule

// File: sv/hett_cell.sv
// one cordic vectoring micro-rotation with its own pipeline register
module hett_cell import hett_pkg::*; #(
    parameter int XY_BITS = 43,
    parameter int SHIFT   = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [XY_BITS-1:0] i_x,
    input  logic signed [XY_BITS-1:0] i_y,
    input  logic [ACC_BITS-1:0]       i_z,
    input  t_flags                    i_flags,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [XY_BITS-1:0] o_x,
    output logic signed [XY_BITS-1:0] o_y,
    output logic [ACC_BITS-1:0]       o_z,
    output t_flags                    o_flags
);

    logic                      r_valid;
    logic signed [XY_BITS-1:0] r_x;
    logic signed [XY_BITS-1:0] r_y;
    logic [ACC_BITS-1:0]       r_z;
    t_flags                    r_flags;

    logic signed [XY_BITS-1:0] x_sh;
    logic signed [XY_BITS-1:0] y_sh;
    logic signed [XY_BITS-1:0] n_x;
    logic signed [XY_BITS-1:0] n_y;
    logic [ACC_BITS-1:0]       n_z;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        x_sh = i_x >>> SHIFT;
        y_sh = i_y >>> SHIFT;
        if (!i_y[XY_BITS-1]) begin
            n_x = i_x + y_sh;
            n_y = i_y - x_sh;
            n_z = i_z + ATAN_TURNS[SHIFT];
        end else begin
            n_x = i_x - y_sh;
            n_y = i_y + x_sh;
            n_z = i_z - ATAN_TURNS[SHIFT];
        end
        // zero offset keeps its seed angle
        if (i_flags.zero) begin
            n_z = i_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_flags = r_flags;

endmodule

// File: sv/hett_post.sv
// output stage: round the accumulator to the output angle width
module hett_post import hett_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ACC_BITS-1:0]   i_z,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ANGLE_BITS-1:0] o_angle
);

    // half an output lsb, zero when the output keeps all accumulator bits
    localparam logic [ACC_BITS-1:0] Round =
        ACC_BITS'((64'd1 << (ACC_BITS - ANGLE_BITS)) >> 1);

    logic                  r_valid;
    logic [ANGLE_BITS-1:0] r_angle;
    logic [ACC_BITS-1:0]   sum;

    assign o_ready = !r_valid || !i_stall;
    assign sum     = i_z + Round;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_angle <= sum[ACC_BITS-1 -: ANGLE_BITS];
        end
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;

endmodule

// File: sv/hett_checker.sv
// port-level checks for the heading error unit, bound to the top level
module hett_checker #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  o_stall,
    input  logic                  o_valid,
    input  logic                  i_stall,
    input  logic [ANGLE_BITS-1:0] o_heading_error
);

    // an empty or moving output stage lets the whole chain move
    a_no_stall_when_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while the output stage can move");

    // reset leaves no result behind
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present right after reset");

    // a stalled result stays put
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_heading_error)))
        else $error("stalled result changed or vanished");

endmodule

bind heading_error_to_target_unit hett_checker #(
    .ANGLE_BITS (ANGLE_BITS)
) u_hett_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_heading_error (o_heading_error)
);
